[hdl/pidc_pkg.sv]
package pidc_pkg;

  localparam int unsigned DATA_WIDTH     = 16;
  localparam int unsigned GAIN_WIDTH     = 16;
  localparam int unsigned ACCUM_WIDTH    = 32;
  localparam int unsigned CFG_DATA_WIDTH = 32;
  localparam int unsigned CFG_IDX_WIDTH  = 3;
  localparam int unsigned FRAC_BITS      = 8;

  localparam logic signed [ACCUM_WIDTH-1:0] ACCUM_LIMIT_DEFAULT = 32'sh0000_ffff;
  localparam logic signed [DATA_WIDTH-1:0]  DRIVE_LIMIT_DEFAULT =
      {1'b0, {(DATA_WIDTH-1){1'b1}}};

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    CFG_ENABLE    = 3'd0,
    CFG_KP_GAIN   = 3'd1,
    CFG_KI_GAIN   = 3'd2,
    CFG_KD_GAIN   = 3'd3,
    CFG_ACCUM_MIN = 3'd4,
    CFG_ACCUM_MAX = 3'd5,
    CFG_DRIVE_MIN = 3'd6,
    CFG_DRIVE_MAX = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] setpoint_value;
    logic signed [DATA_WIDTH-1:0] measured_value;
  } pid_in_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] drive_value;
    logic                         saturated;
  } pid_out_t;

  typedef struct packed {
    logic                          enable;
    logic [GAIN_WIDTH-1:0]         kp_gain;
    logic [GAIN_WIDTH-1:0]         ki_gain;
    logic [GAIN_WIDTH-1:0]         kd_gain;
    logic signed [ACCUM_WIDTH-1:0] accum_min;
    logic signed [ACCUM_WIDTH-1:0] accum_max;
    logic signed [DATA_WIDTH-1:0]  drive_min;
    logic signed [DATA_WIDTH-1:0]  drive_max;
  } cfg_t;

  // Side effects of register writes on controller state.
  typedef struct packed {
    logic enable_rise;
    logic accum_clamp;
    logic drive_clamp;
  } cfg_evt_t;

  // One classified sample on its way from front to back.
  typedef struct packed {
    logic                       hold;
    logic signed [DATA_WIDTH:0] err;
    logic signed [DATA_WIDTH:0] dmeas;
  } op_t;

endpackage

[hdl/pidc_fifo.sv]
module pidc_fifo #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

[hdl/pidc_front.sv]
module pidc_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pidc_pkg::cfg_t     cfg_i,
  input  pidc_pkg::cfg_evt_t evt_i,
  input  logic               push_i,
  output logic               full_o,
  input  pidc_pkg::pid_in_t  in_data_i,
  output logic               op_push_o,
  output pidc_pkg::op_t      op_o,
  input  logic               op_full_i
);

  import pidc_pkg::*;

  logic signed [DATA_WIDTH-1:0] prev_q, prev_d;
  logic                         first_q, first_d;
  logic signed [DATA_WIDTH:0]   sp_x, meas_x, prev_x;
  logic                         accept;

  assign full_o    = op_full_i;
  assign accept    = push_i && !op_full_i;
  assign op_push_o = accept;

  assign sp_x   = (DATA_WIDTH+1)'(in_data_i.setpoint_value);
  assign meas_x = (DATA_WIDTH+1)'(in_data_i.measured_value);
  assign prev_x = (DATA_WIDTH+1)'(prev_q);

  always_comb begin
    op_o.hold  = !cfg_i.enable;
    op_o.err   = sp_x - meas_x;
    // first enabled sample has no derivative
    op_o.dmeas = first_q ? '0 : (meas_x - prev_x);

    prev_d  = prev_q;
    first_d = first_q;
    if (accept && cfg_i.enable) begin
      prev_d  = in_data_i.measured_value;
      first_d = 1'b0;
    end
    if (evt_i.enable_rise) begin
      first_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q  <= '0;
      first_q <= 1'b1;
    end else begin
      prev_q  <= prev_d;
      first_q <= first_d;
    end
  end

endmodule

[hdl/pidc_back.sv]
module pidc_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pidc_pkg::cfg_t     cfg_i,
  input  pidc_pkg::cfg_evt_t evt_i,
  input  logic               op_empty_i,
  output logic               op_pop_o,
  input  pidc_pkg::op_t      op_i,
  input  logic               res_full_i,
  output logic               res_push_o,
  output pidc_pkg::pid_out_t res_o
);

  import pidc_pkg::*;

  localparam int unsigned PW  = GAIN_WIDTH + DATA_WIDTH + 2;   // kp/kd products
  localparam int unsigned KW  = GAIN_WIDTH + 1 + ACCUM_WIDTH;  // ki product
  localparam int unsigned TW  = KW + 1;                        // full sum
  localparam int unsigned SW  = TW - FRAC_BITS;                // after Q8 floor
  localparam int unsigned IW  = ACCUM_WIDTH + 1;

  logic                          adv;

  logic signed [ACCUM_WIDTH-1:0] integ_q, integ_d;
  logic signed [IW-1:0]          isum, ilo, ihi, iclamp;

  logic                          a_valid_q, a_hold_q;
  logic signed [ACCUM_WIDTH-1:0] a_integ_q;
  logic signed [PW-1:0]          a_pkp_q, a_pkd_q;

  logic                          b_valid_q, b_hold_q;
  logic signed [KW-1:0]          b_pki_q;
  logic signed [PW:0]            b_pd_q;

  logic signed [TW-1:0]          total;
  logic signed [SW-1:0]          shifted, dlo, dhi, dclamp;
  logic                          sat;

  logic signed [DATA_WIDTH-1:0]  held_q, held_d, hclamp;

  assign adv        = !res_full_i;
  assign op_pop_o   = adv && !op_empty_i;
  assign res_push_o = adv && b_valid_q;

  // integral update: add error, clamp upper then lower
  always_comb begin
    ilo  = IW'(cfg_i.accum_min);
    ihi  = IW'(cfg_i.accum_max);
    isum = op_pop_o ? (IW'(integ_q) + IW'(op_i.err)) : IW'(integ_q);
    iclamp = isum;
    if (iclamp > ihi) iclamp = ihi;
    if (iclamp < ilo) iclamp = ilo;

    integ_d = integ_q;
    if ((op_pop_o && !op_i.hold) || evt_i.accum_clamp) begin
      integ_d = iclamp[ACCUM_WIDTH-1:0];
    end
  end

  // final sum, Q8 floor, drive clamp and held drive
  always_comb begin
    total   = TW'(b_pki_q) + TW'(b_pd_q);
    shifted = total[TW-1:FRAC_BITS];
    dlo     = SW'(cfg_i.drive_min);
    dhi     = SW'(cfg_i.drive_max);
    sat     = (shifted > dhi) || (shifted < dlo);
    dclamp  = shifted;
    if (dclamp > dhi) dclamp = dhi;
    if (dclamp < dlo) dclamp = dlo;

    hclamp = held_q;
    if (hclamp > cfg_i.drive_max) hclamp = cfg_i.drive_max;
    if (hclamp < cfg_i.drive_min) hclamp = cfg_i.drive_min;

    if (b_hold_q) begin
      res_o.drive_value = held_q;
      res_o.saturated   = 1'b0;
    end else begin
      res_o.drive_value = dclamp[DATA_WIDTH-1:0];
      res_o.saturated   = sat;
    end

    held_d = held_q;
    if (res_push_o && !b_hold_q) begin
      held_d = dclamp[DATA_WIDTH-1:0];
    end else if (evt_i.drive_clamp) begin
      held_d = hclamp;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q   <= '0;
      held_q    <= '0;
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      integ_q <= integ_d;
      held_q  <= held_d;
      if (adv) begin
        a_valid_q <= op_pop_o;
        b_valid_q <= a_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_hold_q  <= op_i.hold;
      a_integ_q <= iclamp[ACCUM_WIDTH-1:0];
      a_pkp_q   <= $signed({1'b0, cfg_i.kp_gain}) * op_i.err;
      a_pkd_q   <= $signed({1'b0, cfg_i.kd_gain}) * op_i.dmeas;
      b_hold_q  <= a_hold_q;
      b_pki_q   <= $signed({1'b0, cfg_i.ki_gain}) * a_integ_q;
      b_pd_q    <= (PW+1)'(a_pkp_q) - (PW+1)'(a_pkd_q);
    end
  end

endmodule

[hdl/pid_controller_clamped.sv]
// Clamped PID controller, one drive value and saturation flag per sample.
// Throughput: one sample per cycle while results are taken; the stage chain
// (integral update, kp/kd products, ki product, sum and clamp) stalls as a whole.
// Path: op queue, then stage a and stage b registers, then the result queue.
// Reset: gains 0, controller disabled, accumulator limits +/-65535, drive limits
// +/-(2^15-1), integral, last measurement and held drive 0, queues empty.
module pid_controller_clamped #(
  parameter int unsigned QUEUE_DEPTH  = 2,
  parameter int unsigned RESULT_DEPTH = 2
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // sample requests
  input  logic                                  push,
  output logic                                  full,
  input  pidc_pkg::pid_in_t                     in_data_i,
  // result requests
  output logic                                  empty,
  input  logic                                  pop,
  output pidc_pkg::pid_out_t                    out_data_o,
  // register writes
  input  logic                                  cfg_we_i,
  input  logic [pidc_pkg::CFG_IDX_WIDTH-1:0]    cfg_idx_i,
  input  logic [pidc_pkg::CFG_DATA_WIDTH-1:0]   cfg_wdata_i
);

  import pidc_pkg::*;

  cfg_t     cfg_q, cfg_d;
  cfg_evt_t evt;
  logic     accum_clamp_q, accum_clamp_d;
  logic     drive_clamp_q, drive_clamp_d;
  logic     enable_rise;

  op_t      front_op, back_op;
  logic     op_push, op_full, op_pop, op_empty;

  pid_out_t res;
  logic     res_push, res_full;

  // ---------------------------------------------------------------------------
  // Register file. Limit writes clamp the integral or the held drive in the
  // cycle after the write against the new limits; enable rising re-arms the
  // zero-derivative first sample in the front end on the write edge itself.
  // ---------------------------------------------------------------------------
  always_comb begin
    cfg_d         = cfg_q;
    enable_rise   = 1'b0;
    accum_clamp_d = 1'b0;
    drive_clamp_d = 1'b0;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_ENABLE: begin
          cfg_d.enable = cfg_wdata_i[0];
          enable_rise  = !cfg_q.enable && cfg_wdata_i[0];
        end
        CFG_KP_GAIN: cfg_d.kp_gain = cfg_wdata_i[GAIN_WIDTH-1:0];
        CFG_KI_GAIN: cfg_d.ki_gain = cfg_wdata_i[GAIN_WIDTH-1:0];
        CFG_KD_GAIN: cfg_d.kd_gain = cfg_wdata_i[GAIN_WIDTH-1:0];
        CFG_ACCUM_MIN: begin
          cfg_d.accum_min = cfg_wdata_i[ACCUM_WIDTH-1:0];
          accum_clamp_d   = 1'b1;
        end
        CFG_ACCUM_MAX: begin
          cfg_d.accum_max = cfg_wdata_i[ACCUM_WIDTH-1:0];
          accum_clamp_d   = 1'b1;
        end
        CFG_DRIVE_MIN: begin
          cfg_d.drive_min = cfg_wdata_i[DATA_WIDTH-1:0];
          drive_clamp_d   = 1'b1;
        end
        CFG_DRIVE_MAX: begin
          cfg_d.drive_max = cfg_wdata_i[DATA_WIDTH-1:0];
          drive_clamp_d   = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enable    <= 1'b0;
      cfg_q.kp_gain   <= '0;
      cfg_q.ki_gain   <= '0;
      cfg_q.kd_gain   <= '0;
      cfg_q.accum_min <= -ACCUM_LIMIT_DEFAULT;
      cfg_q.accum_max <= ACCUM_LIMIT_DEFAULT;
      cfg_q.drive_min <= -DRIVE_LIMIT_DEFAULT;
      cfg_q.drive_max <= DRIVE_LIMIT_DEFAULT;
      accum_clamp_q   <= 1'b0;
      drive_clamp_q   <= 1'b0;
    end else begin
      cfg_q         <= cfg_d;
      accum_clamp_q <= accum_clamp_d;
      drive_clamp_q <= drive_clamp_d;
    end
  end

  assign evt.enable_rise = enable_rise;
  assign evt.accum_clamp = accum_clamp_q;
  assign evt.drive_clamp = drive_clamp_q;

  // ---------------------------------------------------------------------------
  // Front end: take the sample, form error and measurement delta, and tag it
  // as a hold request when disabled. It owns the last measurement.
  // ---------------------------------------------------------------------------
  pidc_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .evt_i     (evt),
    .push_i    (push),
    .full_o    (full),
    .in_data_i (in_data_i),
    .op_push_o (op_push),
    .op_o      (front_op),
    .op_full_i (op_full)
  );

  // Short queue so the front keeps taking samples while the back stalls.
  pidc_fifo #(
    .WIDTH ($bits(op_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_op_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (op_push),
    .data_i  (front_op),
    .full_o  (op_full),
    .pop_i   (op_pop),
    .data_o  (back_op),
    .empty_o (op_empty)
  );

  // ---------------------------------------------------------------------------
  // Back end: integral update, three products, Q8 floor, clamp, held drive.
  // ---------------------------------------------------------------------------
  pidc_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .evt_i      (evt),
    .op_empty_i (op_empty),
    .op_pop_o   (op_pop),
    .op_i       (back_op),
    .res_full_i (res_full),
    .res_push_o (res_push),
    .res_o      (res)
  );

  // Result queue: a finished result waits here without blocking new samples.
  pidc_fifo #(
    .WIDTH ($bits(pid_out_t)),
    .DEPTH (RESULT_DEPTH)
  ) u_res_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (out_data_o),
    .empty_o (empty)
  );

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  op_queue_no_overflow: assert property (
    @(posedge clk_i) disable iff (!rst_ni) op_push |-> !op_full
  ) else $error("sample pushed into full op queue");

  res_queue_no_overflow: assert property (
    @(posedge clk_i) disable iff (!rst_ni) res_push |-> !res_full
  ) else $error("result pushed into full result queue");

  accepted_sample_queued: assert property (
    @(posedge clk_i) disable iff (!rst_ni) (push && !full) |=> !op_empty
  ) else $error("accepted sample missing from op queue");

endmodule

[test/tb_pid_controller_clamped.sv]
module tb_pid_controller_clamped;
  import pidc_pkg::*;

  // Clock, reset and block ports; every input starts at a known value.
  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               push        = 1'b0;
  logic               full;
  pid_in_t            in_data_i   = '0;
  logic               empty;
  logic               pop         = 1'b0;
  pid_out_t           out_data_o;
  logic               cfg_we_i    = 1'b0;
  logic [CFG_IDX_WIDTH-1:0]  cfg_idx_i   = '0;
  logic [CFG_DATA_WIDTH-1:0] cfg_wdata_i = '0;

  // Sample requests waiting for the driver, drive results waiting for the block.
  pid_in_t  pending_samples[$];
  pid_out_t expected_drives[$];

  int error_count = 0;
  int gap_left    = 0;
  int stall_left  = 0;
  bit calm        = 1'b0;  // no idling on either side while set

  // Controller shadow: register copies, loaded with their reset values.
  bit     ctl_en      = 1'b0;
  longint gain_p      = 0;
  longint gain_i      = 0;
  longint gain_d      = 0;
  longint acc_lo      = -longint'(ACCUM_LIMIT_DEFAULT);
  longint acc_hi      = longint'(ACCUM_LIMIT_DEFAULT);
  longint drv_lo      = -longint'(DRIVE_LIMIT_DEFAULT);
  longint drv_hi      = longint'(DRIVE_LIMIT_DEFAULT);
  // Controller shadow: running state.
  longint acc_q       = 0;
  longint last_meas   = 0;
  bit     fresh_start = 1'b1;
  longint hold_drive  = 0;

  pid_controller_clamped uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_data_i  (in_data_i),
    .empty      (empty),
    .pop        (pop),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always #4 clk_i = ~clk_i;

  // Upper limit first, then lower, so the lower limit wins when they cross.
  function automatic longint clamp_to(longint x, longint lo, longint hi);
    if (x > hi) x = hi;
    if (x < lo) x = lo;
    return x;
  endfunction

  // Advance the controller shadow by one sample and return the drive it gives.
  function automatic pid_out_t predict_drive(pid_in_t s);
    longint   err;
    longint   meas;
    longint   dmeas;
    longint   total;
    longint   drv;
    pid_out_t r;
    r.saturated = 1'b0;
    // Disabled: repeat the held drive, touch no state.
    if (!ctl_en) begin
      r.drive_value = hold_drive[DATA_WIDTH-1:0];
      return r;
    end
    meas  = longint'($signed(s.measured_value));
    err   = longint'($signed(s.setpoint_value)) - meas;
    acc_q = clamp_to(acc_q + err, acc_lo, acc_hi);
    // The first sample after enable has no derivative.
    dmeas       = fresh_start ? 0 : meas - last_meas;
    last_meas   = meas;
    fresh_start = 1'b0;
    // Arithmetic shift of the Q.8 sum floors toward minus infinity.
    total = gain_p * err + gain_i * acc_q - gain_d * dmeas;
    drv   = total >>> FRAC_BITS;
    r.saturated   = (drv > drv_hi) || (drv < drv_lo);
    drv           = clamp_to(drv, drv_lo, drv_hi);
    hold_drive    = drv;
    r.drive_value = drv[DATA_WIDTH-1:0];
    return r;
  endfunction

  // Drive one register write at the next edge and mirror its effect.
  // The write enable stays high; close_writes lowers it after the last one.
  task automatic set_reg(cfg_idx_e idx, logic [CFG_DATA_WIDTH-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    case (idx)
      CFG_ENABLE: begin
        if (!ctl_en && val[0]) fresh_start = 1'b1;
        ctl_en = val[0];
      end
      CFG_KP_GAIN: gain_p = longint'(val[GAIN_WIDTH-1:0]);
      CFG_KI_GAIN: gain_i = longint'(val[GAIN_WIDTH-1:0]);
      CFG_KD_GAIN: gain_d = longint'(val[GAIN_WIDTH-1:0]);
      CFG_ACCUM_MIN: begin
        acc_lo = longint'($signed(val[ACCUM_WIDTH-1:0]));
        acc_q  = clamp_to(acc_q, acc_lo, acc_hi);
      end
      CFG_ACCUM_MAX: begin
        acc_hi = longint'($signed(val[ACCUM_WIDTH-1:0]));
        acc_q  = clamp_to(acc_q, acc_lo, acc_hi);
      end
      CFG_DRIVE_MIN: begin
        drv_lo     = longint'($signed(val[DATA_WIDTH-1:0]));
        hold_drive = clamp_to(hold_drive, drv_lo, drv_hi);
      end
      CFG_DRIVE_MAX: begin
        drv_hi     = longint'($signed(val[DATA_WIDTH-1:0]));
        hold_drive = clamp_to(hold_drive, drv_lo, drv_hi);
      end
      default: ;
    endcase
  endtask

  // Lower the write enable, then step to the falling edge so the sample
  // queue is filled away from the clocked blocks.
  task automatic close_writes();
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  function automatic void add_sample(int sp, int ms);
    pid_in_t s;
    s.setpoint_value = sp[DATA_WIDTH-1:0];
    s.measured_value = ms[DATA_WIDTH-1:0];
    pending_samples.push_back(s);
  endfunction

  // Hold until every request went in and every drive result came back.
  task automatic drain();
    do @(negedge clk_i);
    while (pending_samples.size() != 0 || expected_drives.size() != 0);
  endtask

  // Gain with junk in the unused upper bits: zero, modest, or anywhere.
  function automatic logic [CFG_DATA_WIDTH-1:0] pick_gain();
    logic [CFG_DATA_WIDTH-1:0] v;
    v = $urandom;
    case ($urandom_range(0, 3))
      0:       v[GAIN_WIDTH-1:0] = '0;
      1:       v[GAIN_WIDTH-1:0] = GAIN_WIDTH'($urandom_range(0, 65535));
      default: v[GAIN_WIDTH-1:0] = GAIN_WIDTH'($urandom_range(0, 1023));
    endcase
    return v;
  endfunction

  // Draw a whole register set and write it in a shuffled order, so the
  // limit writes clamp the state in random orders.
  task automatic shuffle_setup();
    logic [CFG_DATA_WIDTH-1:0] vals[8];
    logic [CFG_DATA_WIDTH-1:0] tmp;
    int order[8];
    int span;
    int j;
    int t;
    tmp    = $urandom;
    tmp[0] = ($urandom_range(0, 7) != 0);
    vals[CFG_ENABLE]  = tmp;
    vals[CFG_KP_GAIN] = pick_gain();
    vals[CFG_KI_GAIN] = pick_gain();
    vals[CFG_KD_GAIN] = pick_gain();
    case ($urandom_range(0, 19))
      0, 1, 2, 3: begin
        vals[CFG_ACCUM_MIN] = 32'h8000_0000;
        vals[CFG_ACCUM_MAX] = 32'h7fff_ffff;
      end
      4, 5, 6, 7, 8: begin
        vals[CFG_ACCUM_MIN] = $urandom;
        vals[CFG_ACCUM_MAX] = $urandom;
      end
      default: begin
        span = $urandom_range(0, 300000);
        vals[CFG_ACCUM_MIN] = -span;
        vals[CFG_ACCUM_MAX] = span;
      end
    endcase
    span = $urandom_range(0, 32767);
    case ($urandom_range(0, 4))
      0: begin
        vals[CFG_DRIVE_MIN] = -32768;
        vals[CFG_DRIVE_MAX] = 32767;
      end
      1: begin
        vals[CFG_DRIVE_MIN] = $urandom_range(0, 65535);
        vals[CFG_DRIVE_MAX] = $urandom_range(0, 65535);
      end
      default: begin
        vals[CFG_DRIVE_MIN] = -span;
        vals[CFG_DRIVE_MAX] = span;
      end
    endcase
    // Junk above the drive limit width must be ignored.
    tmp = $urandom;
    tmp[DATA_WIDTH-1:0] = vals[CFG_DRIVE_MIN][DATA_WIDTH-1:0];
    vals[CFG_DRIVE_MIN] = tmp;
    tmp = $urandom;
    tmp[DATA_WIDTH-1:0] = vals[CFG_DRIVE_MAX][DATA_WIDTH-1:0];
    vals[CFG_DRIVE_MAX] = tmp;
    for (int k = 0; k < 8; k++) order[k] = k;
    for (int k = 7; k > 0; k--) begin
      j        = $urandom_range(0, k);
      t        = order[k];
      order[k] = order[j];
      order[j] = t;
    end
    for (int k = 0; k < 8; k++) set_reg(cfg_idx_e'(order[k]), vals[order[k]]);
  endtask

  // Mostly closed-loop style runs: a setpoint that wanders slowly and a
  // measurement close to it. The rest is noise over the full field range.
  task automatic queue_run(int count);
    int sp;
    sp = int'($urandom_range(0, 4000)) - 2000;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 9) < 6) begin
        sp = sp + int'($urandom_range(0, 40)) - 20;
        add_sample(sp, sp + int'($urandom_range(0, 64)) - 32);
      end else begin
        add_sample($urandom, $urandom);
      end
    end
  endtask

  // Driver: advance the sample queue on each accepted request, predict its
  // drive, and hold a request steady while the block is full.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push && !full) begin
        expected_drives.push_back(predict_drive(in_data_i));
        void'(pending_samples.pop_front());
      end
      if (push && full) begin
        // hold the stalled request as it is
      end else if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        push     <= 1'b0;
      end else if (pending_samples.size() == 0) begin
        push <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        gap_left <= $urandom_range(0, 18);
        push     <= 1'b0;
      end else begin
        push      <= 1'b1;
        in_data_i <= pending_samples[0];
      end
    end
  end

  // Monitor: check each accepted result against the oldest prediction,
  // and drop pop in random bursts to back-pressure the block.
  always @(posedge clk_i) begin
    pid_out_t want;
    if (rst_ni) begin
      if (pop && !empty) begin
        if (expected_drives.size() == 0) begin
          if (error_count < 10)
            $display("%0t: drive result %0d sat %0b with no sample pending",
                     $realtime, out_data_o.drive_value, out_data_o.saturated);
          error_count <= error_count + 1;
        end else begin
          want = expected_drives.pop_front();
          if (out_data_o.drive_value !== want.drive_value ||
              out_data_o.saturated !== want.saturated) begin
            if (error_count < 10)
              $display("%0t: drive mismatch: expected %0d sat %0b, got %0d sat %0b",
                       $realtime, want.drive_value, want.saturated,
                       out_data_o.drive_value, out_data_o.saturated);
            error_count <= error_count + 1;
          end
        end
      end
      if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        pop        <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        stall_left <= $urandom_range(0, 18);
        pop        <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Out of reset the controller is off: extremes come back as a held zero.
    @(negedge clk_i);
    add_sample(32767, -32768);
    add_sample(-32768, 32767);
    drain();

    // Enable with moderate gains: zero derivative on the first sample,
    // floor of a negative Q.8 sum, and both drive limits hit.
    set_reg(CFG_ENABLE, 32'h1);
    set_reg(CFG_KP_GAIN, 32'h0000_0100);
    set_reg(CFG_KI_GAIN, 32'hffff_0010);
    set_reg(CFG_KD_GAIN, 32'h0000_0200);
    close_writes();
    add_sample(0, 0);
    add_sample(100, 40);
    add_sample(100, 80);
    add_sample(-1, 0);
    add_sample(32767, -32768);
    add_sample(-32768, 32767);
    add_sample(5, 5);
    drain();

    // Disable: hold the last drive; narrowing the drive limits clamps it.
    set_reg(CFG_ENABLE, 32'hffff_fffe);
    close_writes();
    add_sample(1000, -1000);
    drain();
    set_reg(CFG_DRIVE_MAX, 32'hdead_fffb);
    set_reg(CFG_DRIVE_MIN, 32'h1234_ff00);
    close_writes();
    add_sample(-1000, 1000);
    drain();
    // Re-enable: the derivative restarts from zero.
    set_reg(CFG_ENABLE, 32'h1);
    close_writes();
    add_sample(20, 3000);
    add_sample(20, -3000);
    drain();

    // Crossed limits on both the accumulator and the drive.
    set_reg(CFG_ACCUM_MIN, 32'd100);
    set_reg(CFG_ACCUM_MAX, -32'sd100);
    set_reg(CFG_DRIVE_MIN, 32'd50);
    set_reg(CFG_DRIVE_MAX, -32'sd50);
    close_writes();
    add_sample(-32768, 32767);
    add_sample(32767, -32768);
    add_sample(0, 0);
    drain();

    // Full-scale gains and widest limits.
    set_reg(CFG_KP_GAIN, 32'h0000_ffff);
    set_reg(CFG_KI_GAIN, 32'h0000_ffff);
    set_reg(CFG_KD_GAIN, 32'h0000_ffff);
    set_reg(CFG_ACCUM_MIN, 32'h8000_0000);
    set_reg(CFG_ACCUM_MAX, 32'h7fff_ffff);
    set_reg(CFG_DRIVE_MIN, 32'h0000_8000);
    set_reg(CFG_DRIVE_MAX, 32'h0000_7fff);
    close_writes();
    add_sample(32767, -32768);
    add_sample(-32768, 32767);
    add_sample(-32768, 32767);
    add_sample(32767, 32767);
    add_sample(0, -1);
    drain();

    // Random register sets, each followed by a run of samples.
    for (int ph = 0; ph < 8; ph++) begin
      shuffle_setup();
      close_writes();
      calm = ($urandom_range(0, 3) == 0);
      queue_run(55);
      drain();
    end

    // Last stretch: controller on, no idling on either side.
    shuffle_setup();
    set_reg(CFG_ENABLE, 32'h1);
    close_writes();
    calm = 1'b1;
    queue_run(60);
    drain();

    repeat (6) @(posedge clk_i);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #4000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

[files.f]
hdl/pidc_pkg.sv
hdl/pidc_fifo.sv
hdl/pidc_front.sv
hdl/pidc_back.sv
hdl/pid_controller_clamped.sv
test/tb_pid_controller_clamped.sv
